// ----- hw/rtl/page_range_mask_filter_unit_assert.svh -----
// Assertion helpers for the page range mask filter
`ifndef PAGE_RANGE_MASK_FILTER_UNIT_ASSERT_SVH
`define PAGE_RANGE_MASK_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRMF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PRMF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prmf_pkg.sv -----
package prmf_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned LgW    = 5;
  localparam int unsigned HW     = 6;
  localparam logic [LgW-1:0] LgResetVal = 5'd12;

  // result status codes
  typedef enum logic [2:0] {
    ST_CHECKED  = 3'd0,
    ST_EXTENDED = 3'd1,
    ST_CREATED  = 3'd2,
    ST_SKIPPED  = 3'd3,
    ST_FULL     = 3'd4,
    ST_COVERED  = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_RD,
    S_CHK,
    S_DECIDE,
    S_LEN,
    S_END,
    S_LAST,
    S_PREFIX,
    S_NARROW,
    S_WRITE,
    S_DONE
  } state_e;

  // one table entry
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] length;
    logic [AddrW-1:0] bits;
    logic [AddrW-1:0] mask;
  } slot_t;

  // operands of the shared adder/comparator
  typedef struct packed {
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
    logic [AddrW-1:0] c;
  } alu_op_t;

  typedef struct packed {
    logic [AddrW-1:0] sum;
    logic             eq;
    logic             gt;
  } alu_res_t;

endpackage

// ----- hw/rtl/prmf_req_if.sv -----
interface prmf_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [prmf_pkg::AddrW-1:0]   address;
  logic                         in_mapped_object;

  modport source (output valid, output req_type, output address,
                  output in_mapped_object, input ready);
  modport sink   (input valid, input req_type, input address,
                  input in_mapped_object, output ready);
endinterface

// ----- hw/rtl/prmf_rsp_if.sv -----
interface prmf_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [2:0] status;
  logic [2:0] slot_index;

  modport source (output valid, output hit, output status, output slot_index,
                  input ready);
  modport sink   (input valid, input hit, input status, input slot_index,
                  output ready);
endinterface

// ----- hw/rtl/prmf_alu.sv -----
// Shared 64-bit adder with compare of the sum against a third operand
module prmf_alu (
  input  prmf_pkg::alu_op_t  op_i,
  output prmf_pkg::alu_res_t res_o
);

  logic [prmf_pkg::AddrW-1:0] sum;

  assign sum       = op_i.a + op_i.b;
  assign res_o.sum = sum;
  assign res_o.eq  = (sum == op_i.c);
  assign res_o.gt  = (sum > op_i.c);

endmodule

// ----- hw/rtl/prmf_slot_store.sv -----
// Slot table: one write and one registered read per cycle, valid bit per slot
module prmf_slot_store #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr_i,
  output prmf_pkg::slot_t                             rd_data_o,
  output logic                                        rd_valid_o,
  input  logic                                        wr_en_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr_i,
  input  prmf_pkg::slot_t                             wr_data_i
);

  prmf_pkg::slot_t      mem [SLOTS];
  logic [SLOTS-1:0]     valid_q;

  // table storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr_i];
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_o <= valid_q[rd_addr_i];
    end
  end

endmodule

// ----- hw/rtl/page_range_mask_filter_unit.sv -----
// Channel   Dir  Fields                                   Handshake
// req_i     in   req_type, address[63:0], in_mapped_object valid/ready
// rsp_o     out  hit, status[2:0], slot_index[2:0]         valid/ready
// cfg       in   cfg_wdata_i[4:0] (page_shift)             cfg_we_i, no wait
//
// One transaction at a time; req_i.ready is high only while the sequencer idles.
// A check scans every slot once; an insert goes on through the length, end, last-byte,
// prefix search, narrowing and write states (one shared adder).
// A finished result waits in the output register; the next request is taken
// meanwhile, and a second result stalls in the final state until it drains.
// Reset is asynchronous active low and empties every slot at once.
module page_range_mask_filter_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [prmf_pkg::LgW-1:0]     cfg_wdata_i,
  prmf_req_if.sink                     req_i,
  prmf_rsp_if.source                   rsp_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned AW = prmf_pkg::AddrW;
  localparam int unsigned HW = prmf_pkg::HW;

  prmf_pkg::state_e   state_q, state_d;

  // configuration
  logic [prmf_pkg::LgW-1:0] lg_q;
  logic [prmf_pkg::LgW-1:0] lg_eff;

  // captured request
  logic          req_type_q, mapped_q;
  logic [AW-1:0] addr_q;

  // scan bookkeeping
  logic [CW-1:0] cnt_q, cnt_d;
  logic          match_found_q, match_found_d;
  logic          free_found_q, free_found_d;
  logic          ext_found_q, ext_found_d;
  logic [SW-1:0] match_idx_q, match_idx_d;
  logic [SW-1:0] free_idx_q, free_idx_d;
  logic [SW-1:0] tgt_idx_q, tgt_idx_d;

  // range arithmetic
  logic [AW-1:0] page_plus_q, page_plus_d;
  logic [AW-1:0] cur_start_q, cur_start_d;
  logic [AW-1:0] cur_len_q, cur_len_d;
  logic [AW-1:0] end_q, end_d;
  logic [AW-1:0] diff_q, diff_d;
  logic [HW-1:0] h_q, h_d;

  // pending result
  logic                 res_hit_q, res_hit_d;
  prmf_pkg::status_e    res_status_q, res_status_d;
  logic [SW-1:0]        res_slot_q, res_slot_d;

  // output register
  logic                 out_valid_q;
  logic                 out_hit_q;
  prmf_pkg::status_e    out_status_q;
  logic [SW-1:0]        out_slot_q;
  logic [SW+2:0]        out_slot_ext;
  logic                 out_load;

  // derived values
  logic [AW-1:0] psize, page, mask_h, size_h, bits_h;
  logic          is_match, fwd, bwd, narrow;
  logic          req_fire;

  prmf_pkg::alu_op_t  alu_op;
  prmf_pkg::alu_res_t alu_res;

  prmf_pkg::slot_t    rd_data;
  logic               rd_valid;
  logic               wr_en;
  prmf_pkg::slot_t    wr_data;

  prmf_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  prmf_slot_store #(
    .SLOTS (SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (cnt_q[SW-1:0]),
    .rd_data_o  (rd_data),
    .rd_valid_o (rd_valid),
    .wr_en_i    (wr_en),
    .wr_addr_i  (tgt_idx_q),
    .wr_data_i  (wr_data)
  );

  // page geometry
  assign lg_eff = (lg_q == '0) ? prmf_pkg::LgW'(1) : lg_q;
  assign psize  = AW'(1) << lg_eff;
  assign page   = addr_q & ({AW{1'b1}} << lg_eff);

  // region of the current prefix length
  assign mask_h = {AW{1'b1}} << h_q;
  assign size_h = AW'(1) << h_q;
  assign bits_h = cur_start_q & mask_h;

  // per-slot tests during the scan
  assign is_match = rd_valid && ((addr_q & rd_data.mask) == rd_data.bits);
  assign fwd      = rd_valid && alu_res.eq;
  assign bwd      = rd_valid && (rd_data.start == page_plus_q);

  // narrowing continues while the region spills out and is above a page
  assign narrow = (((cur_start_q & ~mask_h) != '0) || alu_res.gt)
                  && (h_q > {1'b0, lg_eff});

  assign req_fire = req_i.valid && req_i.ready;
  assign out_load = (state_q == prmf_pkg::S_DONE) && (!out_valid_q || rsp_o.ready);

  assign wr_en        = (state_q == prmf_pkg::S_WRITE);
  assign wr_data      = '{start: cur_start_q, length: cur_len_q, bits: bits_h,
                          mask: mask_h};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      prmf_pkg::S_IDLE:   if (req_i.valid) state_d = prmf_pkg::S_PREP;
      prmf_pkg::S_PREP:   state_d = prmf_pkg::S_RD;
      prmf_pkg::S_RD:     state_d = prmf_pkg::S_CHK;
      prmf_pkg::S_CHK: begin
        if (cnt_q == CW'(SLOTS - 1)) state_d = prmf_pkg::S_DECIDE;
        else                         state_d = prmf_pkg::S_RD;
      end
      prmf_pkg::S_DECIDE: begin
        priority if (!req_type_q || match_found_q || mapped_q) begin
          state_d = prmf_pkg::S_DONE;
        end else if (ext_found_q || free_found_q) begin
          state_d = prmf_pkg::S_LEN;
        end else begin
          state_d = prmf_pkg::S_DONE;
        end
      end
      prmf_pkg::S_LEN:    state_d = prmf_pkg::S_END;
      prmf_pkg::S_END:    state_d = prmf_pkg::S_LAST;
      prmf_pkg::S_LAST:   state_d = prmf_pkg::S_PREFIX;
      prmf_pkg::S_PREFIX: begin
        if ((h_q == '0) || diff_q[h_q]) state_d = prmf_pkg::S_NARROW;
      end
      prmf_pkg::S_NARROW: if (!narrow) state_d = prmf_pkg::S_WRITE;
      prmf_pkg::S_WRITE:  state_d = prmf_pkg::S_DONE;
      prmf_pkg::S_DONE:   if (out_load) state_d = prmf_pkg::S_IDLE;
      default:            state_d = prmf_pkg::S_IDLE;
    endcase
  end

  // datapath and shared adder control
  always_comb begin
    cnt_d         = cnt_q;
    match_found_d = match_found_q;
    free_found_d  = free_found_q;
    ext_found_d   = ext_found_q;
    match_idx_d   = match_idx_q;
    free_idx_d    = free_idx_q;
    tgt_idx_d     = tgt_idx_q;
    page_plus_d   = page_plus_q;
    cur_start_d   = cur_start_q;
    cur_len_d     = cur_len_q;
    end_d         = end_q;
    diff_d        = diff_q;
    h_d           = h_q;
    res_hit_d     = res_hit_q;
    res_status_d  = res_status_q;
    res_slot_d    = res_slot_q;
    alu_op        = '{a: rd_data.start, b: rd_data.length, c: page};

    unique case (state_q)
      prmf_pkg::S_PREP: begin
        alu_op        = '{a: page, b: psize, c: page};
        page_plus_d   = alu_res.sum;
        cnt_d         = '0;
        match_found_d = 1'b0;
        free_found_d  = 1'b0;
        ext_found_d   = 1'b0;
      end
      prmf_pkg::S_CHK: begin
        // lowest matching, lowest free and lowest extendable slot
        if (is_match && !match_found_q) begin
          match_found_d = 1'b1;
          match_idx_d   = cnt_q[SW-1:0];
        end
        if (!rd_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = cnt_q[SW-1:0];
        end
        if ((fwd || bwd) && !ext_found_q) begin
          ext_found_d = 1'b1;
          tgt_idx_d   = cnt_q[SW-1:0];
          cur_start_d = fwd ? rd_data.start : page;
          cur_len_d   = rd_data.length;
        end
        cnt_d = cnt_q + CW'(1);
      end
      prmf_pkg::S_DECIDE: begin
        res_hit_d  = 1'b0;
        res_slot_d = '0;
        priority if (!req_type_q) begin
          res_status_d = prmf_pkg::ST_CHECKED;
          res_hit_d    = match_found_q;
          if (match_found_q) res_slot_d = match_idx_q;
        end else if (match_found_q) begin
          res_status_d = prmf_pkg::ST_COVERED;
          res_hit_d    = 1'b1;
          res_slot_d   = match_idx_q;
        end else if (mapped_q) begin
          res_status_d = prmf_pkg::ST_SKIPPED;
        end else if (ext_found_q) begin
          res_status_d = prmf_pkg::ST_EXTENDED;
          res_slot_d   = tgt_idx_q;
        end else if (free_found_q) begin
          // new one-page range: zero length plus one page in the next step
          res_status_d = prmf_pkg::ST_CREATED;
          res_slot_d   = free_idx_q;
          tgt_idx_d    = free_idx_q;
          cur_start_d  = page;
          cur_len_d    = '0;
        end else begin
          res_status_d = prmf_pkg::ST_FULL;
        end
      end
      prmf_pkg::S_LEN: begin
        alu_op    = '{a: cur_len_q, b: psize, c: end_q};
        cur_len_d = alu_res.sum;
      end
      prmf_pkg::S_END: begin
        alu_op = '{a: cur_start_q, b: cur_len_q, c: end_q};
        end_d  = alu_res.sum;
      end
      prmf_pkg::S_LAST: begin
        // last byte = end - 1; keep the bits where first and last differ
        alu_op = '{a: end_q, b: {AW{1'b1}}, c: end_q};
        diff_d = cur_start_q ^ alu_res.sum;
        h_d    = HW'(AW - 1);
      end
      prmf_pkg::S_PREFIX: begin
        if ((h_q != '0) && !diff_q[h_q]) h_d = h_q - HW'(1);
      end
      prmf_pkg::S_NARROW: begin
        alu_op = '{a: bits_h, b: size_h, c: end_q};
        if (narrow) h_d = h_q - HW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= prmf_pkg::S_IDLE;
      lg_q          <= prmf_pkg::LgResetVal;
      cnt_q         <= '0;
      match_found_q <= 1'b0;
      free_found_q  <= 1'b0;
      ext_found_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      match_found_q <= match_found_d;
      free_found_q  <= free_found_d;
      ext_found_q   <= ext_found_d;
      if (cfg_we_i) lg_q <= cfg_wdata_i;
      if (out_load)                          out_valid_q <= 1'b1;
      else if (rsp_o.ready)                  out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      req_type_q <= req_i.req_type;
      addr_q     <= req_i.address;
      mapped_q   <= req_i.in_mapped_object;
    end
    match_idx_q  <= match_idx_d;
    free_idx_q   <= free_idx_d;
    tgt_idx_q    <= tgt_idx_d;
    page_plus_q  <= page_plus_d;
    cur_start_q  <= cur_start_d;
    cur_len_q    <= cur_len_d;
    end_q        <= end_d;
    diff_q       <= diff_d;
    h_q          <= h_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (out_load) begin
      out_hit_q    <= res_hit_q;
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  // ports
  assign req_i.ready      = (state_q == prmf_pkg::S_IDLE);
  assign out_slot_ext     = {3'b000, out_slot_q};
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_index = out_slot_ext[2:0];

  // checks
`include "page_range_mask_filter_unit_assert.svh"

  `PRMF_ASSERT_NEXT(a_fire_starts, clk_i, rst_ni, req_fire,
                    state_q == prmf_pkg::S_PREP,
                    "accepted request did not start the sequencer")
  `PRMF_ASSERT_NOW(a_write_insert_only, clk_i, rst_ni, wr_en,
                   req_type_q && !match_found_q && !mapped_q,
                   "slot written for a request that must leave the table alone")
  `PRMF_ASSERT_NOW(a_change_no_hit, clk_i, rst_ni,
                   rsp_o.valid && ((rsp_o.status == prmf_pkg::ST_EXTENDED) ||
                                   (rsp_o.status == prmf_pkg::ST_CREATED)),
                   !rsp_o.hit, "table change reported with a hit")

endmodule

// ----- dv/prmf_tb_pkg.sv -----
`timescale 1ns / 1ps
package prmf_tb_pkg;

  // request kinds carried in req_type
  typedef enum logic {
    REQ_CHECK  = 1'b0,
    REQ_INSERT = 1'b1
  } req_kind_e;

endpackage

// ----- dv/prmf_filter_predictor.sv -----
`timescale 1ns / 1ps
module prmf_filter_predictor #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [prmf_pkg::LgW-1:0] cfg_wdata_i,
  prmf_req_if                   req_mon,
  prmf_rsp_if                   rsp_mon,
  output int unsigned           pending_o,
  output int unsigned           fail_count_o
);
  import prmf_pkg::*;
  import prmf_tb_pkg::*;

  // one predicted response
  typedef struct packed {
    logic       hit;
    status_e    status;
    logic [2:0] slot;
  } verdict_t;

  verdict_t verdict_q[$];

  // shadow copy of the range table and the page size register
  logic [AddrW-1:0] rng_start [SLOTS];
  logic [AddrW-1:0] rng_len   [SLOTS];
  logic [AddrW-1:0] rng_bits  [SLOTS];
  logic [AddrW-1:0] rng_mask  [SLOTS];
  logic [LgW-1:0]   page_lg;

  // an exponent of zero behaves as one
  function automatic logic [AddrW-1:0] page_bytes();
    logic [LgW-1:0] lg;
    lg = (page_lg == '0) ? LgW'(1) : page_lg;
    return 64'd1 << lg;
  endfunction

  // lowest valid slot whose masked bits match, or -1
  function automatic int lowest_match(logic [AddrW-1:0] addr);
    for (int i = 0; i < SLOTS; i++) begin
      if (rng_mask[i] != '0 && (addr & rng_mask[i]) == rng_bits[i]) return i;
    end
    return -1;
  endfunction

  // common prefix of first and last byte, then narrow until the region fits
  function automatic void fit_mask(int s, logic [AddrW-1:0] psz);
    logic [AddrW-1:0] lo, limit, common, mask, bits, span;
    int unsigned h;
    lo     = rng_start[s];
    limit  = rng_start[s] + rng_len[s];
    common = ~(lo ^ (limit - 64'd1));
    h      = 63;
    while (h > 0 && common[h]) h--;
    mask = ~((64'd1 << h) - 64'd1);
    bits = lo & mask;
    span = ~mask + 64'd1;
    while (((bits < lo) || (bits + span > limit)) && (span > psz)) begin
      mask = {1'b1, mask[AddrW-1:1]};
      bits = lo & mask;
      span = ~mask + 64'd1;
    end
    rng_mask[s] = mask;
    rng_bits[s] = bits;
  endfunction

  // expected response for one request, updating the table on insert
  function automatic verdict_t predict_verdict(req_kind_e kind, logic [AddrW-1:0] addr,
                                               logic mapped);
    verdict_t v;
    logic [AddrW-1:0] psz, pg;
    int found, sel;
    psz   = page_bytes();
    pg    = addr & ~(psz - 64'd1);
    found = lowest_match(addr);
    sel   = -1;
    v.hit    = 1'b0;
    v.status = ST_CHECKED;
    v.slot   = '0;
    if (kind == REQ_CHECK) begin
      if (found >= 0) begin
        v.hit  = 1'b1;
        v.slot = 3'(found);
      end
    end else if (found >= 0) begin
      // already covered takes priority over the mapped-object skip
      v.hit    = 1'b1;
      v.status = ST_COVERED;
      v.slot   = 3'(found);
    end else if (mapped) begin
      v.status = ST_SKIPPED;
    end else begin
      // extend: forward before backward, lowest valid slot first
      for (int i = 0; i < SLOTS && sel < 0; i++) begin
        if (rng_mask[i] == '0) continue;
        if (rng_start[i] + rng_len[i] == pg) begin
          rng_len[i] += psz;
          sel = i;
        end else if (rng_start[i] - psz == pg) begin
          rng_start[i] -= psz;
          rng_len[i]   += psz;
          sel = i;
        end
      end
      if (sel >= 0) begin
        v.status = ST_EXTENDED;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (rng_mask[i] == '0) begin
            sel = i;
            break;
          end
        end
        if (sel >= 0) begin
          rng_start[sel] = pg;
          rng_len[sel]   = psz;
          v.status       = ST_CREATED;
        end else begin
          v.status = ST_FULL;
        end
      end
      if (sel >= 0) begin
        fit_mask(sel, psz);
        v.slot = 3'(sel);
      end
    end
    return v;
  endfunction

  // watch both channels; compare before predicting so an early response is caught
  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        rng_start[i] = '0;
        rng_len[i]   = '0;
        rng_bits[i]  = '0;
        rng_mask[i]  = '0;
      end
      page_lg = LgResetVal;
      verdict_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) page_lg = cfg_wdata_i;

      if (rsp_mon.valid && rsp_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("response transaction with nothing expected");
          fail_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (rsp_mon.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp_mon.hit);
            fail_count_o++;
          end
          if (rsp_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
            fail_count_o++;
          end
          if (rsp_mon.slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, rsp_mon.slot_index);
            fail_count_o++;
          end
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        verdict_q.push_back(predict_verdict(req_kind_e'(req_mon.req_type),
                                            req_mon.address, req_mon.in_mapped_object));
      end

      pending_o = verdict_q.size();
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import prmf_pkg::*;
  import prmf_tb_pkg::*;

  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 276;
  localparam int unsigned LONG_HOLD   = 700;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam logic [LgW-1:0] PHASE_LG [6] = '{5'd1, 5'd0, 5'd31, 5'd30, 5'd7, 5'd20};

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we;
  logic [LgW-1:0] cfg_wdata;
  logic [LgW-1:0] cur_lg = LgResetVal;
  int unsigned    pending;
  int unsigned    fail_count;
  bit             sender_calm;
  logic [AddrW-1:0] anchor_q[$];

  prmf_req_if req_if();
  prmf_rsp_if rsp_if();

  page_range_mask_filter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  prmf_filter_predictor u_predictor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // offer one request transaction and wait until it is taken
  task automatic send_item(input req_kind_e kind, input logic [AddrW-1:0] addr,
                           input logic mapped);
    int unsigned gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid            <= 1'b1;
    req_if.req_type         <= kind;
    req_if.address          <= addr;
    req_if.in_mapped_object <= mapped;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // drain, then change the page size while the block is idle
  task automatic write_page_log(input logic [LgW-1:0] lg);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= lg;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_lg = lg;
  endtask

  // response side: random stalls, quiet stretches and two long hold-offs
  initial begin
    int unsigned drained;
    int unsigned idle;
    drained = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    rsp_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        drained++;
        if (drained == 400 || drained == 1300) idle = LONG_HOLD;
        else if ((drained / 200) % 3 == 1) idle = 0;
        else idle = pick_gap();
        if (idle > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (idle) @(posedge clk_i);
          rsp_if.ready <= 1'b1;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [AddrW-1:0] psz, addr;
    req_kind_e kind;
    logic      mapped;
    int unsigned roll;

    req_if.valid            <= 1'b0;
    req_if.req_type         <= REQ_CHECK;
    req_if.address          <= '0;
    req_if.in_mapped_object <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    sender_calm             = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset page size, empty table first
    send_item(REQ_CHECK,  64'h0, 1'b0);
    send_item(REQ_CHECK,  '1, 1'b0);
    send_item(REQ_INSERT, 64'h0000_0000_1234_5000, 1'b1);   // mapped, skipped
    send_item(REQ_INSERT, '1, 1'b0);                        // top page created
    send_item(REQ_INSERT, 64'h0, 1'b0);                     // forward across the wrap
    send_item(REQ_CHECK,  64'h0000_0000_0000_0FFF, 1'b0);
    send_item(REQ_INSERT, '1, 1'b1);                        // covered beats mapped
    send_item(REQ_INSERT, 64'h0000_0000_1234_5678, 1'b0);
    send_item(REQ_INSERT, 64'h0000_0000_1234_4FFF, 1'b0);   // backward
    send_item(REQ_INSERT, 64'h0000_0000_1234_6000, 1'b0);   // forward
    send_item(REQ_CHECK,  64'h0000_0000_1234_5ABC, 1'b0);
    send_item(REQ_INSERT, 64'h0000_0000_1234_5ABC, 1'b0);
    send_item(REQ_INSERT, 64'h5555_0000_0000_0000, 1'b0);
    send_item(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_item(REQ_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0);
    send_item(REQ_INSERT, 64'h8000_0000_0000_0000, 1'b0);
    send_item(REQ_INSERT, 64'h7FFF_FFFF_FFFF_F000, 1'b0);
    send_item(REQ_INSERT, 64'h0000_0000_0000_3000, 1'b0);
    send_item(REQ_INSERT, 64'h9999_0000_0000_0000, 1'b0);   // takes the last free slot
    send_item(REQ_CHECK,  64'h9999_0000_0000_0000, 1'b0);
    send_item(REQ_INSERT, 64'h5554_FFFF_FFFF_FFFF, 1'b0);   // backward, far up
    send_item(REQ_CHECK,  64'h5554_FFFF_FFFF_F000, 1'b0);

    anchor_q = '{64'h0, '1, 64'h0000_0000_1234_5000, 64'h5555_0000_0000_0000,
                 64'hAAAA_AAAA_AAAA_A000, 64'h0F0F_0F0F_0F0F_0000,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_F000,
                 64'h0000_0000_0000_3000};

    // random phases, each under its own page size
    for (int p = 0; p < PHASES; p++) begin
      write_page_log((p < 6) ? PHASE_LG[p] : LgW'($urandom_range(0, 31)));
      psz = 64'd1 << ((cur_lg == '0) ? 1 : cur_lg);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_calm = ((n / 60) % 4 == 3);
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          addr = {$urandom, $urandom};
        end else if (roll < 15) begin
          case ($urandom_range(0, 3))
            0:       addr = '0;
            1:       addr = '1;
            2:       addr = 64'h8000_0000_0000_0000;
            default: addr = {32'hFFFF_FFFF, 32'($urandom)};
          endcase
        end else begin
          // within a few pages of a known range
          addr = anchor_q[$urandom_range(0, anchor_q.size() - 1)]
                 + 64'($urandom_range(0, 8)) * psz - 64'd4 * psz
                 + ({$urandom, $urandom} & (psz - 64'd1));
        end
        if ($urandom_range(0, 7) == 0) begin
          anchor_q.push_back(addr);
          if (anchor_q.size() > 32) void'(anchor_q.pop_front());
        end
        kind   = ($urandom_range(0, 1) == 1) ? REQ_INSERT : REQ_CHECK;
        mapped = (kind == REQ_INSERT) ? ($urandom_range(0, 99) < 15) : 1'($urandom_range(0, 1));
        send_item(kind, addr, mapped);
      end
    end

    // drain and let any stray response show up
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
